### design/skht_pkg.sv
package skht_pkg;

  localparam int unsigned MAX_BUCKETS        = 16;
  localparam int unsigned MIN_BUCKETS        = 10;
  localparam int unsigned ENTRIES_PER_BUCKET = 9;
  localparam int unsigned KEY_BYTES          = 32;
  localparam int unsigned VALUE_BITS         = 16;
  localparam int unsigned ENTRY_TOTAL        = MAX_BUCKETS * ENTRIES_PER_BUCKET;
  localparam int unsigned ENTRY_CHARS        = ENTRY_TOTAL * KEY_BYTES;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned BKT_W  = $clog2(MAX_BUCKETS);
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned LEN_W  = $clog2(KEY_BYTES + 2);
  localparam int unsigned KIDX_W = $clog2(KEY_BYTES);
  localparam int unsigned FILL_W = $clog2(ENTRIES_PER_BUCKET + 1);
  localparam int unsigned SLOT_W = $clog2(ENTRY_TOTAL);
  localparam int unsigned CADR_W = SLOT_W + KIDX_W;
  localparam int unsigned DIV_W  = $clog2(HASH_W);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_TOO_LONG  = 2'd3
  } status_e;

  typedef struct packed {
    logic [LEN_W-1:0]      len;
    logic [VALUE_BITS-1:0] value;
  } meta_t;

endpackage

### design/string_key_hash_table_core.sv
// Hash table keyed by strings that arrive one character per input transfer; the
// transfer with key_last_i set starts a store or look-up and yields one result.
// Characters are taken only while idle. A final character of a key that is not
// over-long then starts the bucket modulo (one remainder bit a cycle) and the fill
// check; a store into a full bucket ends there. Otherwise each stored entry that
// is examined has its length read and then its characters compared one by one
// (the entry memories have one read port), a miss closes the walk, a store miss
// then copies the key into the next free entry, and a done state presents the
// result. The bucket count is written on every cfg transfer (cfg_ready_o is held
// high); write it only between keys, with no result pending.
module string_key_hash_table_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [7:0]                        key_char_i,
  input  logic                              key_last_i,
  input  logic [skht_pkg::VALUE_BITS-1:0]   store_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [skht_pkg::VALUE_BITS-1:0]   found_value_o,
  output logic [skht_pkg::BKT_W-1:0]        bucket_index_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [4:0]                        cfg_data_i
);
  import skht_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_SLOT = 8'b0000_1000,
    S_LEN  = 8'b0001_0000,
    S_CHR  = 8'b0010_0000,
    S_CPY  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]            bcount_q;
  logic [HASH_W-1:0]     hash_q;
  logic [LEN_W-1:0]      len_q;
  logic [LEN_W-1:0]      klen_q;
  logic                  mode_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [HASH_W-1:0]     div_q;
  logic [4:0]            rem_q;
  logic [DIV_W-1:0]      dcnt_q;
  logic [BKT_W-1:0]      bucket_q;
  logic [FILL_W-1:0]     fill_q [MAX_BUCKETS];
  logic [FILL_W-1:0]     idx_q;
  logic [LEN_W-1:0]      j_q;
  logic [VALUE_BITS-1:0] hitval_q;
  status_e               res_status_q;
  logic [VALUE_BITS-1:0] res_found_q;
  logic [BKT_W-1:0]      res_bucket_q;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [VALUE_BITS-1:0] out_found_q;
  logic [BKT_W-1:0]      out_bucket_q;

  logic [CHAR_W-1:0] kbuf_mem [KEY_BYTES];
  logic [CHAR_W-1:0] chars_mem [ENTRY_CHARS];
  meta_t             meta_mem [ENTRY_TOTAL];
  logic [CHAR_W-1:0] kbuf_rd_q;
  logic [CHAR_W-1:0] chars_rd_q;
  meta_t             meta_rd_q;

  logic                  in_xfer;
  logic [HASH_W-1:0]     hash_n;
  logic [LEN_W-1:0]      len_n;
  logic [4:0]            eff;
  logic [4:0]            rem_t;
  logic [4:0]            rem_n;
  logic [FILL_W-1:0]     fill_cur;
  logic [SLOT_W-1:0]     base;
  logic [SLOT_W-1:0]     slot;
  logic [KIDX_W-1:0]     rd_idx;
  logic                  cpy_wr;
  meta_t                 meta_wd;
  logic                  meta_we;
  logic                  out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;

  assign hash_n = {hash_q[HASH_W-6:0], hash_q[HASH_W-1:HASH_W-5]} ^ HASH_W'(key_char_i);
  assign len_n  = (len_q <= LEN_W'(KEY_BYTES)) ? len_q + 1'b1 : len_q;

  always_comb begin
    if (bcount_q < 5'(MIN_BUCKETS)) begin
      eff = 5'(MIN_BUCKETS);
    end else if (bcount_q > 5'(MAX_BUCKETS)) begin
      eff = 5'(MAX_BUCKETS);
    end else begin
      eff = bcount_q;
    end
  end

  assign rem_t = {rem_q[3:0], div_q[HASH_W-1]};
  assign rem_n = (rem_t >= eff) ? rem_t - eff : rem_t;

  assign fill_cur = fill_q[bucket_q];
  assign base     = SLOT_W'(bucket_q) * SLOT_W'(ENTRIES_PER_BUCKET);
  assign slot     = base + SLOT_W'((state_q == S_CPY) ? fill_cur : idx_q);

  always_comb begin
    if (state_q == S_CPY) begin
      rd_idx = j_q[KIDX_W-1:0];
    end else if (state_q == S_CHR) begin
      rd_idx = KIDX_W'(j_q + 1'b1);
    end else begin
      rd_idx = '0;
    end
  end

  assign cpy_wr   = (state_q == S_CPY) && (j_q != '0);
  assign meta_wd  = '{len: klen_q, value: val_q};
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    meta_we = 1'b0;
    if (state_q == S_CPY && j_q == klen_q) begin
      meta_we = 1'b1;
    end
    if (state_q == S_CHR && chars_rd_q == kbuf_rd_q && j_q + 1'b1 == klen_q && mode_q) begin
      meta_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && len_q < LEN_W'(KEY_BYTES)) begin
      kbuf_mem[len_q[KIDX_W-1:0]] <= key_char_i;
    end
    kbuf_rd_q <= kbuf_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cpy_wr) begin
      chars_mem[{slot, KIDX_W'(j_q - 1'b1)}] <= kbuf_rd_q;
    end
    chars_rd_q <= chars_mem[{slot, rd_idx}];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[slot] <= meta_wd;
    end
    meta_rd_q <= meta_mem[slot];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && key_last_i) begin
          state_d = (len_n > LEN_W'(KEY_BYTES)) ? S_DONE : S_DIV;
        end
      end
      S_DIV:  if (dcnt_q == DIV_W'(HASH_W - 1)) state_d = S_CHK;
      S_CHK: begin
        if (mode_q && fill_cur >= FILL_W'(ENTRIES_PER_BUCKET)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        if (idx_q == fill_cur) begin
          state_d = mode_q ? S_CPY : S_DONE;
        end else begin
          state_d = S_LEN;
        end
      end
      S_LEN:  state_d = (meta_rd_q.len == klen_q) ? S_CHR : S_SLOT;
      S_CHR: begin
        if (chars_rd_q != kbuf_rd_q) begin
          state_d = S_SLOT;
        end else if (j_q + 1'b1 == klen_q) begin
          state_d = S_DONE;
        end
      end
      S_CPY:  if (j_q == klen_q) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bcount_q    <= 5'(MIN_BUCKETS);
      hash_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < MAX_BUCKETS; b++) begin
        fill_q[b] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        bcount_q <= cfg_data_i;
      end
      if (in_xfer) begin
        hash_q <= key_last_i ? '0 : hash_n;
        len_q  <= key_last_i ? '0 : len_n;
      end
      if (state_q == S_CPY && j_q == klen_q) begin
        fill_q[bucket_q] <= fill_cur + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        klen_q       <= len_n;
        mode_q       <= mode_i;
        val_q        <= store_value_i;
        div_q        <= hash_n;
        rem_q        <= '0;
        dcnt_q       <= '0;
        res_status_q <= STATUS_TOO_LONG;
        res_found_q  <= '0;
        res_bucket_q <= '0;
      end
      S_DIV: begin
        rem_q  <= rem_n;
        div_q  <= {div_q[HASH_W-2:0], 1'b0};
        dcnt_q <= dcnt_q + 1'b1;
        if (dcnt_q == DIV_W'(HASH_W - 1)) begin
          bucket_q     <= rem_n[BKT_W-1:0];
          res_bucket_q <= rem_n[BKT_W-1:0];
        end
      end
      S_CHK: begin
        idx_q        <= '0;
        res_status_q <= STATUS_FULL;
      end
      S_SLOT: begin
        j_q          <= '0;
        res_status_q <= mode_q ? STATUS_OK : STATUS_NOT_FOUND;
      end
      S_LEN: begin
        j_q      <= '0;
        hitval_q <= meta_rd_q.value;
        if (meta_rd_q.len != klen_q) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      S_CHR: begin
        if (chars_rd_q != kbuf_rd_q) begin
          idx_q <= idx_q + 1'b1;
        end else if (j_q + 1'b1 == klen_q) begin
          res_status_q <= STATUS_OK;
          res_found_q  <= mode_q ? '0 : hitval_q;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      S_CPY: begin
        j_q          <= j_q + 1'b1;
        res_status_q <= STATUS_OK;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_bucket_q <= res_bucket_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_value_o  = out_found_q;
  assign bucket_index_o = out_bucket_q;

endmodule

### design/skht_checker.sv
module skht_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [1:0]                      status_o,
  input logic [skht_pkg::VALUE_BITS-1:0] found_value_o,
  input logic [skht_pkg::BKT_W-1:0]      bucket_index_o
);
  import skht_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(found_value_o) && $stable(bucket_index_o))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> found_value_o == '0)
    else $error("nonzero value on failed transfer");

  a_long_bucket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_TOO_LONG |-> bucket_index_o == '0)
    else $error("bucket set on over-long key");

endmodule

bind string_key_hash_table_core skht_checker u_skht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .found_value_o  (found_value_o),
  .bucket_index_o (bucket_index_o)
);

### sim/tb_top.sv
module tb_top;
  import skht_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned RANDOM_CHARS = 1100;
  localparam int unsigned POOL_SIZE = 48;
  localparam int unsigned MAX_KEY = KEY_BYTES + 8;

  typedef struct {
    status_e          status;
    logic [15:0]      value;
    logic [BKT_W-1:0] bucket;
  } lookup_res_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  mode;
  logic [7:0]            key_char;
  logic                  key_last;
  logic [VALUE_BITS-1:0] store_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            status;
  logic [VALUE_BITS-1:0] found_value;
  logic [BKT_W-1:0]      bucket_index;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [4:0]            cfg_data;

  string_key_hash_table_core u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (mode),
    .key_char_i    (key_char),
    .key_last_i    (key_last),
    .store_value_i (store_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .found_value_o (found_value),
    .bucket_index_o(bucket_index),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  // table shadow
  int unsigned bucket_cfg;
  logic [31:0] hash_acc;
  int unsigned key_len;
  logic [7:0]  key_buf [KEY_BYTES];
  int unsigned bucket_fill [MAX_BUCKETS];
  logic [7:0]  entry_chars [ENTRY_TOTAL][KEY_BYTES];
  int unsigned entry_len [ENTRY_TOTAL];
  logic [15:0] entry_val [ENTRY_TOTAL];

  lookup_res_t pending_results [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned random_chars;
  bit          quiet;
  int unsigned rx_stall;

  logic [7:0]  pool_chars [POOL_SIZE][MAX_KEY];
  int unsigned pool_len [POOL_SIZE];

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit entry_hit(int unsigned slot);
    if (entry_len[slot] != key_len) return 1'b0;
    for (int unsigned i = 0; i < key_len && i < KEY_BYTES; i++) begin
      if (entry_chars[slot][i] != key_buf[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit predict_char(input logic md, input logic [7:0] ch, input logic lst,
                                      input logic [15:0] v, output lookup_res_t r);
    int unsigned eff;
    int unsigned b;
    int unsigned f;
    int unsigned base;
    int unsigned slot;
    bit hit;
    hash_acc = {hash_acc[26:0], hash_acc[31:27]} ^ {24'd0, ch};
    if (key_len < KEY_BYTES) key_buf[key_len] = ch;
    if (key_len <= KEY_BYTES) key_len++;
    r.status = STATUS_OK;
    r.value = '0;
    r.bucket = '0;
    if (!lst) return 1'b0;
    if (key_len > KEY_BYTES) begin
      r.status = STATUS_TOO_LONG;
    end else begin
      eff = bucket_cfg < MIN_BUCKETS ? MIN_BUCKETS :
            bucket_cfg > MAX_BUCKETS ? MAX_BUCKETS : bucket_cfg;
      b = hash_acc % eff;
      r.bucket = b[BKT_W-1:0];
      f = bucket_fill[b];
      base = b * ENTRIES_PER_BUCKET;
      if (md && f >= ENTRIES_PER_BUCKET) begin
        r.status = STATUS_FULL;
      end else begin
        hit = 1'b0;
        slot = 0;
        for (int unsigned i = 0; i < f && !hit; i++) begin
          if (entry_hit(base + i)) begin
            hit = 1'b1;
            slot = base + i;
          end
        end
        if (md) begin
          if (!hit) begin
            slot = base + f;
            for (int unsigned i = 0; i < key_len; i++) entry_chars[slot][i] = key_buf[i];
            entry_len[slot] = key_len;
            bucket_fill[b] = f + 1;
          end
          entry_val[slot] = v;
        end else if (hit) begin
          r.value = entry_val[slot];
        end else begin
          r.status = STATUS_NOT_FOUND;
        end
      end
    end
    hash_acc = '0;
    key_len = 0;
    return 1'b1;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic send_char(input logic md, input logic [7:0] ch, input logic lst,
                           input logic [15:0] v);
    int unsigned gap;
    lookup_res_t r;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= md;
    key_char    <= ch;
    key_last    <= lst;
    store_value <= v;
    do @(posedge clk); while (!in_ready);
    if (predict_char(md, ch, lst, v, r)) pending_results.push_back(r);
    random_chars++;
  endtask

  task automatic send_pool_key(input int unsigned k, input logic md, input logic [15:0] v);
    for (int unsigned i = 0; i < pool_len[k]; i++) begin
      send_char(md, pool_chars[k][i], i == pool_len[k] - 1, v);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_buckets(input logic [4:0] n);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    bucket_cfg = n;
    cfg_valid <= 1'b0;
  endtask

  // one-character keys land in bucket char mod 10 at reset
  task automatic test_full_bucket();
    for (int unsigned i = 0; i < ENTRIES_PER_BUCKET; i++) begin
      send_char(1'b1, 8'(3 + 10 * i), 1'b1, 16'(16'h1000 + i));
    end
    send_char(1'b1, 8'd3, 1'b1, 16'h5555);
    send_char(1'b1, 8'd93, 1'b1, 16'h5555);
    send_char(1'b0, 8'd3, 1'b1, 16'h0);
    send_char(1'b0, 8'd83, 1'b1, 16'h0);
  endtask

  task automatic test_directed();
    send_char(1'b0, 8'd255, 1'b1, 16'hffff);
    send_char(1'b1, 8'd255, 1'b1, 16'hffff);
    send_char(1'b0, 8'd255, 1'b1, 16'h0);
    send_char(1'b1, 8'd1, 1'b1, 16'h0);
    send_char(1'b0, 8'd1, 1'b1, 16'hffff);
    send_char(1'b1, 8'd0, 1'b0, 16'h0);
    send_char(1'b1, 8'd7, 1'b1, 16'ha5a5);
    send_char(1'b0, 8'd0, 1'b0, 16'h0);
    send_char(1'b0, 8'd7, 1'b1, 16'h0);
    send_char(1'b1, 8'd255, 1'b1, 16'h1234);
    send_char(1'b0, 8'd255, 1'b1, 16'h0);
  endtask

  task automatic build_pool();
    int unsigned r;
    for (int unsigned k = 0; k < POOL_SIZE; k++) begin
      r = $urandom_range(99);
      pool_len[k] = r < 80 ? $urandom_range(4, 1) :
                    r < 90 ? $urandom_range(KEY_BYTES, 5) :
                    r < 95 ? KEY_BYTES : $urandom_range(MAX_KEY, KEY_BYTES + 1);
      for (int unsigned i = 0; i < MAX_KEY; i++) pool_chars[k][i] = 8'($urandom_range(255, 1));
    end
  endtask

  task automatic random_keys(input int unsigned chars);
    int unsigned stop;
    int unsigned r;
    int unsigned n;
    stop = random_chars + chars;
    while (random_chars < stop) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_pool_key($urandom_range(POOL_SIZE - 1), 1'($urandom), 16'($urandom));
      end else if (r < 92) begin
        n = $urandom_range(6, 1);
        for (int unsigned i = 0; i < n; i++) begin
          send_char(1'($urandom), 8'($urandom_range(255, 1)), i == n - 1, 16'($urandom));
        end
      end else begin
        // abandon a pool key after its first character, then restart it so the fragment joins it
        n = $urandom_range(POOL_SIZE - 1);
        send_char(1'($urandom), pool_chars[n][0], 1'b0, 16'($urandom));
        send_pool_key(n, 1'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic test_random();
    build_pool();
    random_keys(250);
    write_buckets(5'd16);
    random_keys(200);
    quiet = 1'b1;
    write_buckets(5'd0);
    random_keys(150);
    quiet = 1'b0;
    write_buckets(5'd31);
    random_keys(150);
    write_buckets(5'd13);
    random_keys(200);
    write_buckets(5'd9);
    random_keys(150);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    mode        = 1'b0;
    key_char    = 8'd1;
    key_last    = 1'b0;
    store_value = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    bucket_cfg  = MIN_BUCKETS;
    hash_acc    = '0;
    key_len     = 0;
    error_count = 0;
    random_chars = 0;
    quiet       = 1'b0;
    foreach (bucket_fill[i]) bucket_fill[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_full_bucket();
    test_directed();
    write_buckets(5'd10);
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial out_ready = 1'b0;

  always @(posedge clk) begin
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_ready <= 1'b0;
    end else if (quiet || $urandom_range(99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      rx_stall <= $urandom_range(99) < 90 ? $urandom_range(3, 1) : $urandom_range(60, 20);
      out_ready <= 1'b0;
    end
  end

  initial rx_stall = 0;

  always @(posedge clk) begin
    lookup_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result, status", status, 0);
      end else begin
        e = pending_results.pop_front();
        if (status != e.status) report("status", status, e.status);
        if (found_value != e.value) report("found_value", found_value, e.value);
        if (bucket_index != e.bucket) report("bucket_index", bucket_index, e.bucket);
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
